FILE: design/assert_macros.svh
// Assertion macros used by the escape stripper top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property with the check held off while reset is asserted.
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define AES_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/aes_pkg.sv
// Package with the shared constants and types of the escape stripper.
package aes_pkg;

  // Byte codes recognised by the parser.
  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] BEL_CHAR   = 8'h07;
  localparam logic [7:0] CSI_CHAR   = 8'h5B;
  localparam logic [7:0] OSC_CHAR   = 8'h5D;
  localparam logic [7:0] BSLASH_CHR = 8'h5C;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;

  // Kept-byte counter: width and saturation point.
  localparam int unsigned COUNT_W        = 17;
  localparam int unsigned MAX_LINE_BYTES = 65536;
  localparam int unsigned COUNT_MAX_ALL  = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    (MAX_LINE_BYTES > COUNT_MAX_ALL) ? COUNT_W'(COUNT_MAX_ALL) : COUNT_W'(MAX_LINE_BYTES);

  // Per-byte verdict from the parser.
  typedef struct packed {
    logic               keep;
    logic [COUNT_W-1:0] count;
  } aes_result_t;

endpackage

FILE: design/aes_parser.sv
// Escape-sequence parser: mode state, keep decision and kept-byte counter.
module aes_parser
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        line_end,
  output aes_result_t result
);

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_CSI     = 3'd2,
    MODE_OSC     = 3'd3,
    MODE_OSC_ESC = 3'd4
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               keep;
  mode_t              osc_next;

  // Next mode for an ordinary byte inside an OSC body.
  always_comb begin
    priority if (in_byte == BEL_CHAR) begin
      osc_next = MODE_NORMAL;
    end else if (in_byte == ESC_CHAR) begin
      osc_next = MODE_OSC_ESC;
    end else begin
      osc_next = MODE_OSC;
    end
  end

  // Mode transition and keep decision for the current byte.
  always_comb begin
    keep     = 1'b0;
    mode_nxt = MODE_NORMAL;
    unique case (mode_r)
      MODE_ESC: begin
        if (in_byte == CSI_CHAR) begin
          mode_nxt = MODE_CSI;
        end else if (in_byte == OSC_CHAR) begin
          mode_nxt = MODE_OSC;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        mode_nxt = (in_byte >= FINAL_LO && in_byte <= FINAL_HI) ? MODE_NORMAL : MODE_CSI;
      end
      MODE_OSC: begin
        mode_nxt = osc_next;
      end
      MODE_OSC_ESC: begin
        mode_nxt = (in_byte == BSLASH_CHR) ? MODE_NORMAL : osc_next;
      end
      default: begin
        // Normal text; a lone ESC at the end of the line is kept.
        if (in_byte == ESC_CHAR && !line_end) begin
          mode_nxt = MODE_ESC;
        end else begin
          keep     = 1'b1;
          mode_nxt = MODE_NORMAL;
        end
      end
    endcase
  end

  // Saturating count of kept bytes, including this one.
  always_comb begin
    total_nxt = total_r;
    if (keep && total_r < COUNT_LIMIT) begin
      total_nxt = total_r + COUNT_W'(1);
    end
  end

  assign result.keep  = keep;
  assign result.count = total_nxt;

  // State advances on each accepted beat and returns to reset after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      total_r <= '0;
    end else if (accept) begin
      if (line_end) begin
        mode_r  <= MODE_NORMAL;
        total_r <= '0;
      end else begin
        mode_r  <= mode_nxt;
        total_r <= total_nxt;
      end
    end
  end

endmodule

FILE: design/ansi_escape_stripper.sv
// Top level of the terminal escape-sequence stripper.
// Each accepted input beat gives its result beat from the result register in the next cycle.
// One byte per cycle while the consumer takes results; the parser state loop and the result register set this.
// A waiting result does not block the input while the consumer takes it in the same cycle.
// Reset (synchronous, active low) returns to normal text mode with a zero count
// and an empty result register.
module ansi_escape_stripper
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [24:8] kept_count, [31:25] zero
  output logic        out_tuser,  // keep
  output logic        out_tlast   // out_last
);

`include "assert_macros.svh"

  logic               in_accept;
  aes_result_t        result;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_keep_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_count_r;

  // Input is taken whenever the result register is empty or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  aes_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_byte  (in_tdata),
    .line_end (in_tlast),
    .result   (result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte_r  <= in_tdata;
      out_keep_r  <= result.keep;
      out_last_r  <= in_tlast;
      out_count_r <= result.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - 8 - COUNT_W){1'b0}}, out_count_r, out_byte_r};
  assign out_tuser  = out_keep_r;
  assign out_tlast  = out_last_r;

  // Checks on the result path.
  `AES_ASSERT(a_accept_gives_result, clk, rst_n, in_accept |=> out_valid_r, "accepted beat did not produce a result")
  `AES_ASSERT(a_count_limit, clk, rst_n, out_valid_r |-> (out_count_r <= COUNT_LIMIT), "kept count beyond saturation limit")
  `AES_ASSERT(a_keep_counted, clk, rst_n, (out_valid_r && out_keep_r) |-> (out_count_r != '0), "kept byte with zero count")
  `AES_ASSERT(a_line_restart, clk, rst_n, (in_accept && $past(in_accept && in_tlast)) |-> (result.count <= COUNT_W'(1)), "count not restarted after line end")
  `AES_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_valid_r, "result valid straight after reset")

endmodule

FILE: tb/sv/tb_ansi_escape_stripper.sv
// Self-checking testbench for the terminal escape-sequence stripper.
module tb_ansi_escape_stripper
  import aes_pkg::*;
();

  localparam int unsigned IDLE_PCT    = 14;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned RAND_ITEMS  = 1460;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 10;

  // Parser modes as the stripper walks through a line.
  typedef enum logic [2:0] {
    PM_TEXT    = 3'd0,
    PM_ESC     = 3'd1,
    PM_CSI     = 3'd2,
    PM_OSC     = 3'd3,
    PM_OSC_ESC = 3'd4
  } parser_mode_e;

  // Kinds of fragment that make up a random line.
  typedef enum int {
    FRAG_TEXT,
    FRAG_CSI,
    FRAG_OSC,
    FRAG_PAIR,
    FRAG_NOISE
  } fragment_e;

  // One predicted verdict beat.
  typedef struct packed {
    logic [7:0]         data;
    logic               keep;
    logic               last;
    logic [COUNT_W-1:0] count;
  } strip_verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // line_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] out_byte, [24:8] kept_count, [31:25] zero
  logic        out_tuser;          // keep
  logic        out_tlast;          // out_last

  // Predictor state and the verdicts still owed by the block.
  parser_mode_e   pred_mode = PM_TEXT;
  logic [COUNT_W-1:0] pred_kept = '0;
  strip_verdict_t strip_verdicts[$];

  int unsigned mismatches = 0;
  int unsigned bytes_accepted = 0;
  bit          quiet = 1'b0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  ansi_escape_stripper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Mode after one byte of an OSC body.
  function automatic parser_mode_e osc_next(logic [7:0] b);
    if (b == BEL_CHAR) return PM_TEXT;
    if (b == ESC_CHAR) return PM_OSC_ESC;
    return PM_OSC;
  endfunction

  // Work out the verdict for one accepted byte and advance the predictor.
  function automatic strip_verdict_t predict_strip(logic [7:0] b, logic last);
    strip_verdict_t v;
    parser_mode_e   nxt;
    logic           keep;
    keep = 1'b0;
    nxt  = PM_TEXT;
    case (pred_mode)
      PM_ESC: begin
        if (b == CSI_CHAR) nxt = PM_CSI;
        else if (b == OSC_CHAR) nxt = PM_OSC;
        else nxt = PM_TEXT;
      end
      PM_CSI: begin
        if (b >= FINAL_LO && b <= FINAL_HI) nxt = PM_TEXT;
        else nxt = PM_CSI;
      end
      PM_OSC: nxt = osc_next(b);
      PM_OSC_ESC: begin
        if (b == BSLASH_CHR) nxt = PM_TEXT;
        else nxt = osc_next(b);
      end
      default: begin
        if (b == ESC_CHAR && !last) nxt = PM_ESC;
        else keep = 1'b1;
      end
    endcase
    if (keep && pred_kept < COUNT_LIMIT) pred_kept = pred_kept + 1'b1;
    v.data  = b;
    v.keep  = keep;
    v.last  = last;
    v.count = pred_kept;
    if (last) begin
      pred_mode = PM_TEXT;
      pred_kept = '0;
    end else begin
      pred_mode = nxt;
    end
    return v;
  endfunction

  // Input monitor and result checker share one block so that the order is fixed.
  always @(posedge clk) begin
    strip_verdict_t want;
    if (rst_n && in_tvalid && in_tready) begin
      strip_verdicts.push_back(predict_strip(in_tdata, in_tlast));
      bytes_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (strip_verdicts.size() == 0) begin
        $error("result beat with no verdict waiting: tdata=%h", out_tdata);
        mismatches++;
      end else begin
        want = strip_verdicts.pop_front();
        if (out_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tuser !== want.keep) begin
          $error("keep: expected %b, actual %b", want.keep, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last: expected %b, actual %b", want.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[24:8] !== want.count) begin
          $error("kept_count: expected %0d, actual %0d", want.count, out_tdata[24:8]);
          mismatches++;
        end
        if (out_tdata[31:25] !== 7'd0) begin
          $error("tdata padding: expected %h, actual %h", 7'd0, out_tdata[31:25]);
          mismatches++;
        end
      end
    end
  end

  // Consumer: random stalls, quiet stretches and long hold-offs on request.
  always @(posedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one byte, with a random idle gap in front, and wait for its acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a whole line; the final byte carries the end-of-line mark.
  task automatic send_line(ref logic [7:0] line[$]);
    foreach (line[i]) send_byte(line[i], i == line.size() - 1);
  endtask

  // Append one random fragment: text, a sequence, or noise, sometimes broken.
  function automatic void append_fragment(ref logic [7:0] line[$]);
    fragment_e   kind;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 40) kind = FRAG_TEXT;
    else if (pick < 60) kind = FRAG_CSI;
    else if (pick < 78) kind = FRAG_OSC;
    else if (pick < 88) kind = FRAG_PAIR;
    else kind = FRAG_NOISE;
    case (kind)
      FRAG_TEXT: begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          b = 8'($urandom_range(255));
          line.push_back(b == ESC_CHAR ? 8'h20 : b);
        end
      end
      FRAG_CSI: begin
        line.push_back(ESC_CHAR);
        line.push_back(CSI_CHAR);
        n = $urandom_range(3);
        repeat (n) line.push_back(8'($urandom_range(8'h3F, 8'h20)));
        if ($urandom_range(9) == 0) line.push_back(8'($urandom_range(255)));
        if ($urandom_range(9) != 0) line.push_back(8'($urandom_range(FINAL_HI, FINAL_LO)));
      end
      FRAG_OSC: begin
        line.push_back(ESC_CHAR);
        line.push_back(OSC_CHAR);
        n = $urandom_range(6);
        repeat (n) begin
          b = 8'($urandom_range(255));
          if (b == BEL_CHAR) b = 8'h41;
          // An occasional ESC inside the body that is not a terminator.
          if (b == ESC_CHAR || $urandom_range(15) == 0) begin
            line.push_back(ESC_CHAR);
            b = 8'h71;
          end
          line.push_back(b);
        end
        pick = $urandom_range(9);
        if (pick < 5) begin
          line.push_back(BEL_CHAR);
        end else if (pick < 9) begin
          line.push_back(ESC_CHAR);
          line.push_back(BSLASH_CHR);
        end
      end
      FRAG_PAIR: begin
        line.push_back(ESC_CHAR);
        line.push_back(8'($urandom_range(255)));
      end
      default: begin
        n = $urandom_range(3, 1);
        repeat (n) begin
          if ($urandom_range(2) == 0) line.push_back(ESC_CHAR);
          else line.push_back(8'($urandom_range(255)));
        end
      end
    endcase
  endfunction

  // Extremes of the byte range and each kind of sequence, complete and cut.
  task automatic test_directed_sequences();
    logic [7:0] line[$];
    // Plain bytes at both extremes, then a CSI sequence.
    line = '{8'h00, 8'hFF, ESC_CHAR, CSI_CHAR, 8'h33, 8'h6D, 8'h78};
    send_line(line);
    // OSC closed by BEL, an ordinary ESC pair and a lone ESC at the end of the line.
    line = '{ESC_CHAR, OSC_CHAR, 8'h61, BEL_CHAR, ESC_CHAR, 8'h63, ESC_CHAR};
    send_line(line);
    // ESC inside OSC without a backslash, then the proper ESC backslash close.
    line = '{ESC_CHAR, OSC_CHAR, ESC_CHAR, 8'h71, ESC_CHAR, BSLASH_CHR, 8'h7A};
    send_line(line);
    // CSI cut by the end of the line.
    line = '{ESC_CHAR, CSI_CHAR, 8'h31};
    send_line(line);
    // ESC as the last byte of an OSC body.
    line = '{ESC_CHAR, OSC_CHAR, ESC_CHAR};
    send_line(line);
  endtask

  // A long hold-off at the consumer while the producer keeps offering text.
  task automatic test_output_backpressure();
    logic [7:0] line[$];
    line = {};
    repeat (60) line.push_back(8'($urandom_range(8'h7E, 8'h20)));
    holds_requested <= holds_requested + 1;
    send_line(line);
  endtask

  // Mostly well-formed lines with random content, with a quiet stretch in the middle.
  task automatic test_random_lines();
    logic [7:0]  line[$];
    int unsigned start;
    int unsigned frags;
    start = bytes_accepted;
    while (bytes_accepted - start < RAND_ITEMS) begin
      quiet <= (bytes_accepted - start > 600) && (bytes_accepted - start < 900);
      line = {};
      if ($urandom_range(19) == 0) begin
        line.push_back(8'($urandom_range(255)));
      end else begin
        frags = $urandom_range(6, 1);
        repeat (frags) append_fragment(line);
      end
      send_line(line);
    end
    quiet <= 1'b0;
  endtask

  // Run watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sequences();
    test_output_backpressure();
    test_random_lines();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (strip_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
